// ===== rtl/two_queue_priority_service_unit_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the two-queue priority service unit
// shared clocking and reset for implication checks
// ----------------------------------------------------------------------------
`ifndef TWO_QUEUE_PRIORITY_SERVICE_UNIT_ASSERT_SVH
`define TWO_QUEUE_PRIORITY_SERVICE_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define TQPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define TQPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/tqps_pkg.sv =====
// ----------------------------------------------------------------------------
// tqps_pkg
// types, widths and codes shared by the priority service unit
// ----------------------------------------------------------------------------
package tqps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QI_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int LIMIT_W     = 5;
  localparam int LIM_CMP_W   = (QC_W > LIMIT_W) ? QC_W : LIMIT_W;

  localparam int ID_W       = 16;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 32;
  localparam int TOT_W      = 48;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = ID_W + TIME_W;
  localparam int OUT_DATA_W = ID_W + TIME_W + 7 * CNT_W + 2 * TOT_W;

  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
  localparam logic [TOT_W-1:0]   TOT_MAX     = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  // config port
  localparam int   CFG_ADDR_W      = 3;
  localparam int   CFG_DATA_W      = 32;
  localparam logic REG_QUEUE_LIMIT = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_HIGH   = 2'd1,
    REQ_LOW    = 2'd2,
    REQ_UNUSED = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED    = 3'd0,
    ST_REFUSED     = 3'd1,
    ST_IDLE        = 3'd2,
    ST_SERVED_HIGH = 3'd3,
    ST_SERVED_LOW  = 3'd4
  } status_t;

  // classified operation handed from front to back
  typedef enum logic [3:0] {
    OP_SERVE    = 4'b0001,
    OP_ENQ_HIGH = 4'b0010,
    OP_ENQ_LOW  = 4'b0100,
    OP_NOP      = 4'b1000
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t entry;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/tqps_front.sv =====
// ----------------------------------------------------------------------------
// tqps_front
// input register stage, decodes the request kind into an operation
// ----------------------------------------------------------------------------
module tqps_front
  import tqps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  entry_t            in_entry,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  logic vld_r;
  cmd_t cmd_r;
  op_t  op_dec;

  always_comb begin
    case (in_kind)
      REQ_TICK: op_dec = OP_SERVE;
      REQ_HIGH: op_dec = OP_ENQ_HIGH;
      REQ_LOW:  op_dec = OP_ENQ_LOW;
      default:  op_dec = OP_NOP;
    endcase
  end

  assign in_ready  = !vld_r || cmd_ready;
  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (cmd_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= '{op: op_dec, entry: in_entry};
    end
  end

endmodule

// ===== rtl/tqps_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tqps_cmd_fifo
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module tqps_cmd_fifo
  import tqps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  `include "two_queue_priority_service_unit_assert.svh"

  cmd_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       wr_en;
  logic       rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        wp_r <= !wp_r;
      end
      if (rd_en) begin
        rp_r <= !rp_r;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  `TQPS_ASSERT_NEXT(a_fifo_fill, wr_en && !rd_en, cnt_r == $past(cnt_r) + 2'd1)

endmodule

// ===== rtl/tqps_queue.sv =====
// ----------------------------------------------------------------------------
// tqps_queue
// bounded circular queue of entries with a programmable admission limit
// ----------------------------------------------------------------------------
module tqps_queue
  import tqps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               pop,
  input  entry_t             push_entry,
  input  logic [LIMIT_W-1:0] limit,
  output entry_t             head_entry,
  output qstat_t             stat
);

  `include "two_queue_priority_service_unit_assert.svh"

  localparam logic [QI_W:0]        DEPTH_EXT = (QI_W + 1)'(QUEUE_DEPTH);
  localparam logic [QI_W-1:0]      LAST_IDX  = QI_W'(QUEUE_DEPTH - 1);
  localparam logic [LIM_CMP_W-1:0] DEPTH_LIM = LIM_CMP_W'(QUEUE_DEPTH);
  localparam logic [QC_W-1:0]      DEPTH_CNT = QC_W'(QUEUE_DEPTH);

  entry_t               mem_r [QUEUE_DEPTH];
  logic [QI_W-1:0]      head_r;
  logic [QC_W-1:0]      cnt_r;
  logic [QI_W:0]        tail_sum;
  logic [QI_W-1:0]      tail_idx;
  logic [LIM_CMP_W-1:0] lim_ext;
  logic [LIM_CMP_W-1:0] lim_eff;

  // tail = (head + count) mod depth
  assign tail_sum = {1'b0, head_r} + (QI_W + 1)'(cnt_r);
  assign tail_idx = (tail_sum >= DEPTH_EXT) ? QI_W'(tail_sum - DEPTH_EXT) : QI_W'(tail_sum);

  // limit above depth acts as depth
  assign lim_ext = LIM_CMP_W'(limit);
  assign lim_eff = (lim_ext > DEPTH_LIM) ? DEPTH_LIM : lim_ext;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (LIM_CMP_W'(cnt_r) >= lim_eff);
  assign head_entry = mem_r[head_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (push) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (pop) begin
      cnt_r  <= cnt_r - 1'b1;
      head_r <= (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_idx] <= push_entry;
    end
  end

  `TQPS_ASSERT_IMPL(a_q_bound, 1'b1, cnt_r <= DEPTH_CNT)
  `TQPS_ASSERT_IMPL(a_q_push_room, push, !stat.full && !pop)
  `TQPS_ASSERT_IMPL(a_q_pop_data, pop, !stat.empty)

endmodule

// ===== rtl/tqps_back.sv =====
// ----------------------------------------------------------------------------
// tqps_back
// scheduler core: admission, strict-priority service, statistics, result register
// ----------------------------------------------------------------------------
module tqps_back
  import tqps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  input  logic [LIMIT_W-1:0]    limit,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [STATUS_W-1:0]   res_status,
  output logic [OUT_DATA_W-1:0] res_data
);

  logic go;
  qstat_t hstat;
  qstat_t lstat;
  entry_t hhead;
  entry_t lhead;
  logic h_push, h_pop, l_push, l_pop;

  entry_t            sel_entry;
  logic [TIME_W-1:0] wait_calc;
  logic [TOT_W-1:0]  sel_tot;
  logic [TOT_W:0]    tot_sum;
  logic [TOT_W-1:0]  tot_sat;

  logic                oval_r;
  status_t             status_r, status_nxt;
  logic [ID_W-1:0]     sid_r, sid_nxt;
  logic [TIME_W-1:0]   wait_r, wait_nxt;
  logic [CNT_W-1:0]    hreq_r, hreq_nxt, lreq_r, lreq_nxt;
  logic [CNT_W-1:0]    href_r, href_nxt, lref_r, lref_nxt;
  logic [CNT_W-1:0]    hsrv_r, hsrv_nxt, lsrv_r, lsrv_nxt;
  logic [CNT_W-1:0]    idle_r, idle_nxt;
  logic [TOT_W-1:0]    hwt_r, hwt_nxt, lwt_r, lwt_nxt;

  assign cmd_ready = !oval_r || res_ready;
  assign go        = cmd_valid && cmd_ready;

  assign h_push = go && (cmd.op == OP_ENQ_HIGH) && !hstat.full;
  assign l_push = go && (cmd.op == OP_ENQ_LOW) && !lstat.full;
  assign h_pop  = go && (cmd.op == OP_SERVE) && !hstat.empty;
  assign l_pop  = go && (cmd.op == OP_SERVE) && hstat.empty && !lstat.empty;

  tqps_queue u_hq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (h_push),
    .pop        (h_pop),
    .push_entry (cmd.entry),
    .limit      (limit),
    .head_entry (hhead),
    .stat       (hstat)
  );

  tqps_queue u_lq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (l_push),
    .pop        (l_pop),
    .push_entry (cmd.entry),
    .limit      (limit),
    .head_entry (lhead),
    .stat       (lstat)
  );

  // wait and saturating total for whichever queue is served
  assign sel_entry = hstat.empty ? lhead : hhead;
  assign wait_calc = cmd.entry.stamp - sel_entry.stamp;
  assign sel_tot   = hstat.empty ? lwt_r : hwt_r;
  assign tot_sum   = {1'b0, sel_tot} + (TOT_W + 1)'(wait_calc);
  assign tot_sat   = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];

  always_comb begin
    status_nxt = ST_REFUSED;
    sid_nxt    = '0;
    wait_nxt   = '0;
    hreq_nxt   = hreq_r;
    lreq_nxt   = lreq_r;
    href_nxt   = href_r;
    lref_nxt   = lref_r;
    hsrv_nxt   = hsrv_r;
    lsrv_nxt   = lsrv_r;
    idle_nxt   = idle_r;
    hwt_nxt    = hwt_r;
    lwt_nxt    = lwt_r;
    case (cmd.op)
      OP_ENQ_HIGH: begin
        hreq_nxt = sat_inc(hreq_r);
        if (hstat.full) begin
          href_nxt = sat_inc(href_r);
        end else begin
          status_nxt = ST_ACCEPTED;
        end
      end
      OP_ENQ_LOW: begin
        lreq_nxt = sat_inc(lreq_r);
        if (lstat.full) begin
          lref_nxt = sat_inc(lref_r);
        end else begin
          status_nxt = ST_ACCEPTED;
        end
      end
      OP_SERVE: begin
        if (!hstat.empty) begin
          status_nxt = ST_SERVED_HIGH;
          sid_nxt    = sel_entry.id;
          wait_nxt   = wait_calc;
          hsrv_nxt   = sat_inc(hsrv_r);
          hwt_nxt    = tot_sat;
        end else if (!lstat.empty) begin
          status_nxt = ST_SERVED_LOW;
          sid_nxt    = sel_entry.id;
          wait_nxt   = wait_calc;
          lsrv_nxt   = sat_inc(lsrv_r);
          lwt_nxt    = tot_sat;
        end else begin
          status_nxt = ST_IDLE;
          idle_nxt   = sat_inc(idle_r);
        end
      end
      default: begin
        status_nxt = ST_REFUSED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
      hreq_r <= '0;
      lreq_r <= '0;
      href_r <= '0;
      lref_r <= '0;
      hsrv_r <= '0;
      lsrv_r <= '0;
      idle_r <= '0;
      hwt_r  <= '0;
      lwt_r  <= '0;
    end else begin
      if (go) begin
        oval_r <= 1'b1;
        hreq_r <= hreq_nxt;
        lreq_r <= lreq_nxt;
        href_r <= href_nxt;
        lref_r <= lref_nxt;
        hsrv_r <= hsrv_nxt;
        lsrv_r <= lsrv_nxt;
        idle_r <= idle_nxt;
        hwt_r  <= hwt_nxt;
        lwt_r  <= lwt_nxt;
      end else if (res_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      status_r <= status_nxt;
      sid_r    <= sid_nxt;
      wait_r   <= wait_nxt;
    end
  end

  // statistics only move when a new result loads, so they match the held result
  assign res_valid  = oval_r;
  assign res_status = status_r;
  assign res_data   = {idle_r, lwt_r, hwt_r, lsrv_r, hsrv_r, lref_r, href_r,
                       lreq_r, hreq_r, wait_r, sid_r};

endmodule

// ===== rtl/two_queue_priority_service_unit.sv =====
// ----------------------------------------------------------------------------
// two_queue_priority_service_unit
// two-queue strict-priority scheduler with saturating statistics
// ----------------------------------------------------------------------------
// Every request (tick, high-priority enqueue, low-priority enqueue) gives
// exactly one result. The block sustains one request per clock while
// out_tready is high; each request passes through the input register, the
// two-entry command queue and the scheduler result register before its
// result is valid. The rate is set by the scheduler core, which does
// admission or one dequeue plus all counter updates each time it takes a
// request; the command queue lets the input side keep taking requests
// while a result waits on the output. Queue storage needs no clearing
// after reset, so the block is ready as soon as rst_n rises.
// queue_limit (5 bits, reset 16) lies at byte address 0 and may only be
// written while the block is idle.
// ----------------------------------------------------------------------------
module two_queue_priority_service_unit
  import tqps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entry_id [15:0], time_now [47:16]
  input  logic [KIND_W-1:0]     in_tuser,   // req_type [1:0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // served_id [15:0], wait_time [47:16], high_requests [79:48],
  // low_requests [111:80], high_refused [143:112], low_refused [175:144],
  // high_served [207:176], low_served [239:208], high_wait_total [287:240],
  // low_wait_total [335:288], idle_ticks [367:336]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]   out_tuser,  // status [2:0]
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [LIMIT_W-1:0] limit_r;
  logic               reg_sel;
  entry_t             in_entry;

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  // config register: single word, decoded on the word index
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_QUEUE_LIMIT);
  assign prdata  = reg_sel ? CFG_DATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  // unpack request payload
  assign in_entry = '{id: in_tdata[ID_W-1:0], stamp: in_tdata[IN_DATA_W-1:ID_W]};

  // front: register and classify the request
  tqps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_entry  (in_entry),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // short queue so front and back stall independently
  tqps_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_cmd)
  );

  // back: queues, service decision, statistics, result register
  tqps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (back_valid),
    .cmd_ready  (back_ready),
    .cmd        (back_cmd),
    .limit      (limit_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_status (out_tuser),
    .res_data   (out_tdata)
  );

endmodule
